>>> src/pcbt_pkg.sv
`timescale 1ns / 1ps

package pcbt_pkg;

    // default depth of the break table
    localparam int NUM_CONTEXTS_DEF = 256;

    // page and break granularity, both powers of two
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int BREAK_ALIGN = 8;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration reset values
    localparam logic [31:0] REGION_START_RST = 32'h6000_0000;
    localparam logic [31:0] REGION_END_RST   = 32'h6FFF_FFFF;
    localparam logic [31:0] HIGHMEM_BASE_RST = 32'h8000_0000;

    // input opcodes
    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_BRK    = 2'd1,
        OP_FAULT  = 2'd2
    } t_opcode;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_REGION_START = 2'd0,
        CFG_REGION_END   = 2'd1,
        CFG_HIGHMEM_BASE = 2'd2
    } t_cfg_idx;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_CTX  = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NULL     = 3'd3,
        ST_RESERVED = 3'd4,
        ST_HIGHMEM  = 3'd5,
        ST_BRK_VIOL = 3'd6
    } t_status;

    // decoded command kind
    typedef enum logic [1:0] {
        K_SELECT,
        K_BRK,
        K_FAULT,
        K_NOP
    } t_kind;

    // back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        logic [31:0] region_start;
        logic [31:0] region_end;
        logic [31:0] highmem_base;
    } t_cfg;

    // classified command passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ctx;
        logic        bad_ctx;
        logic        inc_zero;
        logic        shrink;
        t_status     fault_status;
        logic        fault_check;
        logic [31:0] operand;
    } t_cmd;

    // round up to a page boundary, wrapping at 2^32
    function automatic logic [31:0] page_up(input logic [31:0] x);
        logic [31-PAGE_SHIFT:0] hi;
        hi = x[31:PAGE_SHIFT] + (31-PAGE_SHIFT+1)'(|x[PAGE_SHIFT-1:0]);
        return {hi, {PAGE_SHIFT{1'b0}}};
    endfunction

endpackage

>>> src/pcbt_if.sv
`timescale 1ns / 1ps

// request channel
interface pcbt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [7:0]         ctx;
    logic signed [31:0] increment;
    logic [31:0]        fault_addr;

    modport source (output valid, opcode, ctx, increment, fault_addr, input ready);
    modport sink   (input valid, opcode, ctx, increment, fault_addr, output ready);
endinterface

// result channel
interface pcbt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value;
    logic        release_valid;
    logic [31:0] release_start;
    logic [31:0] release_end;
    logic        map_page;

    modport source (output valid, status, value, release_valid, release_start,
                    release_end, map_page, input ready);
    modport sink   (input valid, status, value, release_valid, release_start,
                    release_end, map_page, output ready);
endinterface

>>> src/pcbt_front.sv
`timescale 1ns / 1ps

module pcbt_front
    import pcbt_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    pcbt_req_if.sink i_req,
    input  t_cfg     i_cfg,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [32:0] ALIGN_LOW = 33'(BREAK_ALIGN - 1);

    logic [32:0] w_inc_sum;
    logic [32:0] w_aligned;

    // take a beat whenever the queue has room
    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    // round the increment up to the break alignment, no wrap
    assign w_inc_sum = {i_req.increment[31], i_req.increment} + ALIGN_LOW;
    assign w_aligned = w_inc_sum & ~ALIGN_LOW;

    // decode and pre-classify
    always_comb begin
        o_cmd              = '0;
        o_cmd.kind         = K_NOP;
        o_cmd.ctx          = i_req.ctx;
        o_cmd.bad_ctx      = {1'b0, i_req.ctx} >= 9'(NUM_CONTEXTS);
        o_cmd.inc_zero     = (i_req.increment == '0);
        o_cmd.fault_status = ST_OK;
        unique case (i_req.opcode)
            OP_SELECT: begin
                o_cmd.kind = K_SELECT;
            end
            OP_BRK: begin
                o_cmd.kind    = K_BRK;
                o_cmd.operand = w_aligned[31:0];
                o_cmd.shrink  = w_aligned[32];
            end
            OP_FAULT: begin
                // checks against configuration only, break compare left to back
                o_cmd.kind    = K_FAULT;
                o_cmd.operand = i_req.fault_addr;
                priority if (i_req.fault_addr == '0) begin
                    o_cmd.fault_status = ST_NULL;
                end else if (i_req.fault_addr < i_cfg.region_start) begin
                    o_cmd.fault_status = ST_RESERVED;
                end else if (i_req.fault_addr > i_cfg.highmem_base) begin
                    o_cmd.fault_status = ST_HIGHMEM;
                end else begin
                    o_cmd.fault_check = 1'b1;
                end
            end
            default: begin
                o_cmd.kind = K_NOP;
            end
        endcase
    end

endmodule

>>> src/pcbt_fifo.sv
`timescale 1ns / 1ps

module pcbt_fifo
    import pcbt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> src/pcbt_back.sv
`timescale 1ns / 1ps

module pcbt_back
    import pcbt_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    pcbt_rsp_if.source o_rsp
);

    localparam int IDX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

    t_back_state r_state, n_state;
    t_cmd        r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_active;
    logic [31:0] r_mem [NUM_CONTEXTS];
    logic [NUM_CONTEXTS-1:0] r_vld;
    logic [31:0] r_rd_data;
    logic        r_rd_vld;

    logic        r_out_valid;
    t_status     r_status;
    logic [31:0] r_value;
    logic        r_rel_valid;
    logic [31:0] r_rel_start;
    logic [31:0] r_rel_end;
    logic        r_map;

    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_adv;
    logic [31:0]      w_old;
    logic [31:0]      w_nb;
    logic [31:0]      w_pn;
    logic [31:0]      w_po;
    logic [31:0]      w_pm;
    logic             w_we;
    logic [31:0]      w_wdata;
    logic             w_set_active;
    t_status          n_status;
    logic [31:0]      n_value;
    logic             n_rel_valid;
    logic [31:0]      n_rel_start;
    logic [31:0]      n_rel_end;
    logic             n_map;

    // a valid select reads its own context, everything else the active one
    assign w_rd_addr = (i_cmd.kind == K_SELECT && !i_cmd.bad_ctx) ?
                       i_cmd.ctx[IDX_W-1:0] : r_active;
    assign w_adv     = (r_state == BK_EXEC) && (!r_out_valid || o_rsp.ready);

    // sequencer: read in idle, compute and write back in exec
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        w_rd_en   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    w_rd_en   = 1'b1;
                    n_state   = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (w_adv) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // latch the command and read the break table
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_cmd     <= i_cmd;
            r_idx     <= w_rd_addr;
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
    end

    // an entry never written reads as zero
    assign w_old = r_rd_vld ? r_rd_data : '0;
    assign w_nb  = w_old + r_cmd.operand;
    assign w_pn  = page_up(w_nb);
    assign w_po  = page_up(w_old);
    assign w_pm  = page_up(w_old - 32'(PAGE_BYTES));

    // operation results
    always_comb begin
        w_we         = 1'b0;
        w_wdata      = w_nb;
        w_set_active = 1'b0;
        n_status     = ST_OK;
        n_value      = '0;
        n_rel_valid  = 1'b0;
        n_rel_start  = '0;
        n_rel_end    = '0;
        n_map        = 1'b0;
        unique case (r_cmd.kind)
            K_SELECT: begin
                if (r_cmd.bad_ctx) begin
                    n_status = ST_BAD_CTX;
                end else begin
                    w_set_active = w_adv;
                    w_we         = w_adv && (w_old == '0);
                    w_wdata      = i_cfg.region_start;
                end
            end
            K_BRK: begin
                if (r_cmd.inc_zero) begin
                    n_value = w_old;
                end else if (w_nb < i_cfg.region_start || w_nb > i_cfg.region_end) begin
                    n_status = ST_RANGE;
                    n_value  = '1;
                end else begin
                    w_we    = w_adv;
                    n_value = w_old;
                    // shrink past a page boundary frees whole pages
                    if (r_cmd.shrink && (w_pn < w_pm) && (w_po > w_pn)) begin
                        n_rel_valid = 1'b1;
                        n_rel_start = w_pn;
                        n_rel_end   = w_po;
                    end
                end
            end
            K_FAULT: begin
                n_status = r_cmd.fault_status;
                if (r_cmd.fault_check) begin
                    if (r_cmd.operand < w_old) begin
                        n_map = 1'b1;
                    end else begin
                        n_status = ST_BRK_VIOL;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // valid bits and active context
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_active <= '0;
        end else begin
            if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (w_set_active) begin
                r_active <= r_idx;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status    <= n_status;
            r_value     <= n_value;
            r_rel_valid <= n_rel_valid;
            r_rel_start <= n_rel_start;
            r_rel_end   <= n_rel_end;
            r_map       <= n_map;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.value         = r_value;
    assign o_rsp.release_valid = r_rel_valid;
    assign o_rsp.release_start = r_rel_start;
    assign o_rsp.release_end   = r_rel_end;
    assign o_rsp.map_page      = r_map;

endmodule

>>> src/per_context_break_tracker.sv
// the back end sequencer reads the break table in idle, writes it back in exec
//   and takes no new command from the queue until it is back in idle, which a
//   stalled result beat can hold off
// reset: synchronous active low; clears queue, sequencer, valid bits of the
//   break table and the active context, and loads the region defaults
`timescale 1ns / 1ps

module per_context_break_tracker
    import pcbt_pkg::*;
#(
    parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    pcbt_req_if.sink    i_req,
    pcbt_rsp_if.source  o_rsp
);

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_start <= REGION_START_RST;
            r_cfg.region_end   <= REGION_END_RST;
            r_cfg.highmem_base <= HIGHMEM_BASE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_START: r_cfg.region_start <= i_cfg_data;
                CFG_REGION_END:   r_cfg.region_end   <= i_cfg_data;
                CFG_HIGHMEM_BASE: r_cfg.highmem_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pcbt_front #(
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_front (
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    pcbt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    pcbt_back #(
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_pop),
        .o_rsp       (o_rsp)
    );

endmodule

>>> src/pcbt_checker.sv
`timescale 1ns / 1ps

module pcbt_checker
    import pcbt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_status,
    input logic [31:0] i_value,
    input logic        i_rel_valid,
    input logic [31:0] i_rel_start,
    input logic [31:0] i_rel_end,
    input logic        i_map
);

    // a release range is only reported on a successful shrink, page aligned
    a_release_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rel_valid |->
            i_status == ST_OK && i_rel_start < i_rel_end &&
            i_rel_start[PAGE_SHIFT-1:0] == '0 && i_rel_end[PAGE_SHIFT-1:0] == '0)
        else $error("bad release range");

    // out of range change returns all ones and frees nothing
    a_range_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_RANGE |-> i_value == '1 && !i_rel_valid && !i_map)
        else $error("out of range result malformed");

    // a page mapping request is a clean fault result
    a_map_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_map |-> i_status == ST_OK && !i_rel_valid && i_value == '0)
        else $error("map request with extra fields");

    // stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=>
            i_valid && $stable(i_status) && $stable(i_value) && $stable(i_map))
        else $error("result changed under stall");

endmodule

bind per_context_break_tracker pcbt_checker u_pcbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_rsp.valid),
    .i_ready     (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_value     (o_rsp.value),
    .i_rel_valid (o_rsp.release_valid),
    .i_rel_start (o_rsp.release_start),
    .i_rel_end   (o_rsp.release_end),
    .i_map       (o_rsp.map_page)
);
